FILE: rtl/core/fdtdc_pkg.sv
// Shared types, constants and a saturation helper for the FDTD TE CPML field engine.
package fdtdc_pkg;

	// Field values are signed Q16.16 in a 32-bit word.
	localparam int VW     = 32;
	localparam int FRAC   = 16;
	localparam int DT_W   = 31;
	localparam int IK_W   = 31;
	localparam int EXT_W  = 7;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 31;

	localparam logic signed [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
	localparam logic signed [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};

	// Item kinds.
	localparam logic [2:0] KIND_WCELL  = 3'd0;
	localparam logic [2:0] KIND_WXPROF = 3'd1;
	localparam logic [2:0] KIND_WYPROF = 3'd2;
	localparam logic [2:0] KIND_HSWEEP = 3'd3;
	localparam logic [2:0] KIND_ESWEEP = 3'd4;
	localparam logic [2:0] KIND_READ   = 3'd5;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_COLS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DT   = 2'd2;

	// One CPML profile entry: decay, coupling and reciprocal stretch.
	typedef struct packed {
		logic signed [VW-1:0] b;
		logic signed [VW-1:0] c;
		logic [IK_W-1:0]      ik;
	} prof_t;

	// Write enables for every store.
	typedef struct packed {
		logic ex;
		logic ey;
		logic hz;
		logic coeff;
		logic metal;
		logic phx;
		logic phy;
		logic pex;
		logic pey;
		logic xprof;
		logic yprof;
	} mem_we_t;

	// Read enables: cell port a, neighbor port b, profiles.
	typedef struct packed {
		logic rd_a;
		logic rd_b;
		logic rd_prof;
	} mem_rd_t;

	// Saturated value with its overflow mark.
	typedef struct packed {
		logic                 ovf;
		logic signed [VW-1:0] val;
	} sat_t;

	// Clamp a one-bit-wider sum back into the value range.
	function automatic sat_t sat_sum(input logic signed [VW:0] s);
		sat_t r;
		r.ovf = (s[VW] != s[VW-1]);
		if (r.ovf) begin
			r.val = s[VW] ? VMIN : VMAX;
		end else begin
			r.val = s[VW-1:0];
		end
		return r;
	endfunction

endpackage

FILE: rtl/core/fdtdc_qmul.sv
// Two-stage saturating Q16.16 multiplier with round-to-nearest, ties away from zero.
module fdtdc_qmul import fdtdc_pkg::*; (
	input  logic                 clk,
	input  logic signed [VW-1:0] x,
	input  logic signed [VW-1:0] k,
	output logic signed [VW-1:0] res,
	output logic                 ovf
);
	localparam int PW = 2 * VW;
	localparam int MW = PW - FRAC;
	localparam logic [MW-1:0] LIM_POS = MW'(VMAX);
	localparam logic [MW-1:0] LIM_NEG = LIM_POS + MW'(1);
	localparam logic [PW-1:0] HALF    = PW'(1) << (FRAC - 1);

	logic [VW-1:0] xm, km;
	logic [PW-1:0] prod_s1;
	logic          neg_s1;
	logic [PW-1:0] rnd;
	logic [MW-1:0] mag;
	logic signed [VW-1:0] res_s2;
	logic          ovf_s2;
	logic signed [VW-1:0] res_c;
	logic          ovf_c;

	// Magnitudes of both operands.
	assign xm = x[VW-1] ? (~x + 1'b1) : x;
	assign km = k[VW-1] ? (~k + 1'b1) : k;

	// Stage one: unsigned magnitude product and result sign.
	always_ff @(posedge clk) begin
		prod_s1 <= xm * km;
		neg_s1  <= x[VW-1] ^ k[VW-1];
	end

	// Stage two: round, drop the fraction, restore sign and saturate.
	assign rnd = prod_s1 + HALF;
	assign mag = rnd[PW-1:FRAC];

	always_comb begin
		ovf_c = 1'b0;
		if (neg_s1) begin
			if (mag > LIM_NEG) begin
				ovf_c = 1'b1;
				res_c = VMIN;
			end else if (mag == LIM_NEG) begin
				res_c = VMIN;
			end else begin
				res_c = -$signed(mag[VW-1:0]);
			end
		end else begin
			if (mag > LIM_POS) begin
				ovf_c = 1'b1;
				res_c = VMAX;
			end else begin
				res_c = $signed(mag[VW-1:0]);
			end
		end
	end

	always_ff @(posedge clk) begin
		res_s2 <= res_c;
		ovf_s2 <= ovf_c;
	end

	assign res = res_s2;
	assign ovf = ovf_s2;

endmodule

FILE: rtl/core/fdtdc_store.sv
// Grid and profile memories: one write port, registered reads at cell and neighbor.
module fdtdc_store import fdtdc_pkg::*; #(
	parameter int GRID_ROWS = 64,
	parameter int GRID_COLS = 64
) (
	input  logic                 clk,
	input  mem_we_t              we,
	input  mem_rd_t              rd,
	input  logic [$clog2(GRID_ROWS)+$clog2(GRID_COLS)-1:0] wr_addr,
	input  logic [$clog2(GRID_ROWS)+$clog2(GRID_COLS)-1:0] rd_addr_a,
	input  logic [$clog2(GRID_ROWS)+$clog2(GRID_COLS)-1:0] rd_addr_b,
	input  logic [$clog2(GRID_ROWS)-1:0] x_addr,
	input  logic [$clog2(GRID_COLS)-1:0] y_addr,
	input  logic signed [VW-1:0] ex_wd,
	input  logic signed [VW-1:0] ey_wd,
	input  logic signed [VW-1:0] hz_wd,
	input  logic signed [VW-1:0] coeff_wd,
	input  logic                 metal_wd,
	input  logic signed [VW-1:0] phx_wd,
	input  logic signed [VW-1:0] phy_wd,
	input  logic signed [VW-1:0] pex_wd,
	input  logic signed [VW-1:0] pey_wd,
	input  prof_t                prof_wd,
	output logic signed [VW-1:0] ex_a,
	output logic signed [VW-1:0] ey_a,
	output logic signed [VW-1:0] hz_a,
	output logic signed [VW-1:0] coeff_a,
	output logic                 metal_a,
	output logic signed [VW-1:0] phx_a,
	output logic signed [VW-1:0] phy_a,
	output logic signed [VW-1:0] pex_a,
	output logic signed [VW-1:0] pey_a,
	output logic signed [VW-1:0] ex_b,
	output logic signed [VW-1:0] ey_b,
	output logic signed [VW-1:0] hz_b,
	output prof_t                xp_q,
	output prof_t                yp_q
);
	localparam int AW    = $clog2(GRID_ROWS) + $clog2(GRID_COLS);
	localparam int DEPTH = 1 << AW;

	logic signed [VW-1:0] ex_mem    [DEPTH];
	logic signed [VW-1:0] ey_mem    [DEPTH];
	logic signed [VW-1:0] hz_mem    [DEPTH];
	logic signed [VW-1:0] coeff_mem [DEPTH];
	logic                 metal_mem [DEPTH];
	logic signed [VW-1:0] phx_mem   [DEPTH];
	logic signed [VW-1:0] phy_mem   [DEPTH];
	logic signed [VW-1:0] pex_mem   [DEPTH];
	logic signed [VW-1:0] pey_mem   [DEPTH];
	prof_t                xp_mem    [GRID_ROWS];
	prof_t                yp_mem    [GRID_COLS];

	// Field grids, read at the cell and at one neighbor.
	always_ff @(posedge clk) begin
		if (we.ex) begin
			ex_mem[wr_addr] <= ex_wd;
		end
		if (we.ey) begin
			ey_mem[wr_addr] <= ey_wd;
		end
		if (we.hz) begin
			hz_mem[wr_addr] <= hz_wd;
		end
		if (rd.rd_a) begin
			ex_a <= ex_mem[rd_addr_a];
			ey_a <= ey_mem[rd_addr_a];
			hz_a <= hz_mem[rd_addr_a];
		end
		if (rd.rd_b) begin
			ex_b <= ex_mem[rd_addr_b];
			ey_b <= ey_mem[rd_addr_b];
			hz_b <= hz_mem[rd_addr_b];
		end
	end

	// Per-cell coefficient, metal mark and CPML auxiliary grids.
	always_ff @(posedge clk) begin
		if (we.coeff) begin
			coeff_mem[wr_addr] <= coeff_wd;
		end
		if (we.metal) begin
			metal_mem[wr_addr] <= metal_wd;
		end
		if (we.phx) begin
			phx_mem[wr_addr] <= phx_wd;
		end
		if (we.phy) begin
			phy_mem[wr_addr] <= phy_wd;
		end
		if (we.pex) begin
			pex_mem[wr_addr] <= pex_wd;
		end
		if (we.pey) begin
			pey_mem[wr_addr] <= pey_wd;
		end
		if (rd.rd_a) begin
			coeff_a <= coeff_mem[rd_addr_a];
			metal_a <= metal_mem[rd_addr_a];
			phx_a   <= phx_mem[rd_addr_a];
			phy_a   <= phy_mem[rd_addr_a];
			pex_a   <= pex_mem[rd_addr_a];
			pey_a   <= pey_mem[rd_addr_a];
		end
	end

	// Row and column CPML profiles.
	always_ff @(posedge clk) begin
		if (we.xprof) begin
			xp_mem[x_addr] <= prof_wd;
		end
		if (we.yprof) begin
			yp_mem[y_addr] <= prof_wd;
		end
		if (rd.rd_prof) begin
			xp_q <= xp_mem[x_addr];
			yp_q <= yp_mem[y_addr];
		end
	end

endmodule

FILE: rtl/core/fdtd_te_cpml_field_update.sv
// Top level of the 2D TE Yee-grid field engine with CPML layers and PEC cells.
//
//   channel  | handshake               | contents
//   ---------+-------------------------+------------------------------------------
//   in       | in_valid / in_ready     | kind, indices, cell values, profile entry
//   out      | out_valid / out_ready   | Ex, Ey, Hz, metal mark, saturation flag
//   cfg      | cfg_write               | cfg_index, cfg_data (no wait, no read-back)
//
// A sweep visits every cell of the extent: the H sweep skips cells of the last row or
// column, and the E sweep gives a border cell only the conductor zeroing; one shared
// multiplier and the single-port sequencing of each cell set the sweep time.
// After reset a clearing pass zeroes the field, metal and CPML auxiliary grids,
// one entry per cycle, with in_ready low; the coefficient grid and the profiles are
// not cleared. A result that waits on out_ready does not stop the next transaction
// from being accepted.
module fdtd_te_cpml_field_update import fdtdc_pkg::*; #(
	parameter int GRID_ROWS = 64,
	parameter int GRID_COLS = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [2:0]            kind,
	input  logic [5:0]            index_i,
	input  logic [5:0]            index_j,
	input  logic signed [31:0]    e_x_value,
	input  logic signed [31:0]    e_y_value,
	input  logic signed [31:0]    h_z_value,
	input  logic signed [31:0]    update_coeff,
	input  logic                  is_metal,
	input  logic signed [31:0]    decay_b,
	input  logic signed [31:0]    couple_c,
	input  logic [30:0]           inv_kappa,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic signed [31:0]    e_x_out,
	output logic signed [31:0]    e_y_out,
	output logic signed [31:0]    h_z_out,
	output logic                  metal_out,
	output logic                  saturated
);
	localparam int RW = $clog2(GRID_ROWS);
	localparam int CW = $clog2(GRID_COLS);
	localparam int AW = RW + CW;
	localparam int MXW = (RW > CW) ? RW : CW;
	localparam int NW = (MXW + 1 > EXT_W) ? MXW + 1 : EXT_W;
	localparam logic [3:0] STEP_LAST = 4'd13;

	typedef enum logic [3:0] {
		ST_CLEAR  = 4'b0001,
		ST_IDLE   = 4'b0010,
		ST_RUN    = 4'b0100,
		ST_FINISH = 4'b1000
	} state_t;

	typedef enum logic [2:0] {
		DST_NONE, DST_DA, DST_DB, DST_T0, DST_PA, DST_PB, DST_TA, DST_TB
	} dst_t;

	state_t state_q;
	logic [EXT_W-1:0] rows_q, cols_q;
	logic [DT_W-1:0]  dt_q;
	logic [2:0]       kind_q;
	logic             in_grid_q;
	logic             flag_q;
	logic [AW-1:0]    clr_q;
	logic [RW-1:0]    ci_q;
	logic [CW-1:0]    cj_q;
	logic [3:0]       step_q;
	logic signed [VW-1:0] da_q, db_q, t0_q, pa_q, pb_q, ta_q, tb_q;
	logic             out_valid_q;
	logic signed [VW-1:0] ex_out_q, ey_out_q, hz_out_q;
	logic             metal_out_q, sat_out_q;

	logic             accept;
	logic [RW-1:0]    i_idx;
	logic [CW-1:0]    j_idx;
	logic             i_ok, j_ok, in_grid;
	logic [EXT_W-1:0] nx, ny;
	logic [NW-1:0]    ci_n, cj_n, nx_n, ny_n;
	logic             row_last, col_last, h_active, e_inner, is_h, cell_done;
	logic             out_load;

	mem_we_t          we;
	mem_rd_t          rd;
	logic [AW-1:0]    wr_addr, rd_addr_a, rd_addr_b;
	logic [RW-1:0]    x_addr;
	logic [CW-1:0]    y_addr;
	logic signed [VW-1:0] ex_wd, ey_wd, hz_wd, phx_wd, phy_wd, pex_wd, pey_wd;
	logic             metal_wd;
	prof_t            prof_wd;
	logic signed [VW-1:0] ex_a, ey_a, hz_a, coeff_a, phx_a, phy_a, pex_a, pey_a;
	logic signed [VW-1:0] ex_b, ey_b, hz_b;
	logic             metal_a;
	prof_t            xp_q, yp_q;

	logic signed [VW-1:0] mx, mk, mq_res;
	logic             mq_ovf;
	logic signed [VW-1:0] alu_a, alu_b;
	logic             alu_sub, alu_use, mul_use;
	logic signed [VW:0] alu_sum;
	sat_t             sres;
	dst_t             dst;

	// Input decode and extent clamping.
	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == ST_IDLE);
	assign i_idx    = RW'(index_i);
	assign j_idx    = CW'(index_j);
	assign i_ok     = (32'(index_i) < GRID_ROWS);
	assign j_ok     = (32'(index_j) < GRID_COLS);
	assign in_grid  = i_ok && j_ok;
	assign nx       = (32'(rows_q) > GRID_ROWS) ? EXT_W'(GRID_ROWS) : rows_q;
	assign ny       = (32'(cols_q) > GRID_COLS) ? EXT_W'(GRID_COLS) : cols_q;
	assign ci_n     = NW'(ci_q);
	assign cj_n     = NW'(cj_q);
	assign nx_n     = NW'(nx);
	assign ny_n     = NW'(ny);
	assign row_last = (ci_n + NW'(1) == nx_n);
	assign col_last = (cj_n + NW'(1) == ny_n);
	assign h_active = (ci_n + NW'(1) < nx_n) && (cj_n + NW'(1) < ny_n);
	assign e_inner  = (ci_q != '0) && (cj_q != '0) && h_active;
	assign is_h     = (kind_q == KIND_HSWEEP);
	assign cell_done = (step_q == STEP_LAST)
		|| (is_h && step_q == 4'd0 && !h_active)
		|| (!is_h && step_q == 4'd1 && !e_inner);
	assign out_load = (state_q == ST_FINISH) && (!out_valid_q || out_ready);

	// Per-step multiplier operands and saturating adder for one cell.
	always_comb begin
		mx      = da_q;
		mk      = '0;
		alu_a   = '0;
		alu_b   = '0;
		alu_sub = 1'b0;
		alu_use = 1'b0;
		mul_use = 1'b0;
		dst     = DST_NONE;
		if (is_h) begin
			case (step_q)
				4'd1: begin
					alu_a = ex_b; alu_b = ex_a; alu_sub = 1'b1; alu_use = 1'b1; dst = DST_DA;
				end
				4'd2: begin
					alu_a = ey_b; alu_b = ey_a; alu_sub = 1'b1; alu_use = 1'b1; dst = DST_DB;
					mx = phx_a; mk = xp_q.b;
				end
				4'd3: begin
					mx = db_q; mk = xp_q.c;
				end
				4'd4: begin
					mx = phy_a; mk = yp_q.b;
					alu_a = mq_res; mul_use = 1'b1; dst = DST_T0;
				end
				4'd5: begin
					mx = da_q; mk = yp_q.c;
					alu_a = t0_q; alu_b = mq_res; alu_use = 1'b1; mul_use = 1'b1; dst = DST_PA;
				end
				4'd6: begin
					mx = db_q; mk = {1'b0, xp_q.ik};
					alu_a = mq_res; mul_use = 1'b1; dst = DST_T0;
				end
				4'd7: begin
					mx = da_q; mk = {1'b0, yp_q.ik};
					alu_a = t0_q; alu_b = mq_res; alu_use = 1'b1; mul_use = 1'b1; dst = DST_PB;
				end
				4'd8: begin
					alu_a = mq_res; alu_b = pa_q; alu_use = 1'b1; mul_use = 1'b1; dst = DST_TA;
				end
				4'd9: begin
					alu_a = mq_res; alu_b = pb_q; alu_use = 1'b1; mul_use = 1'b1; dst = DST_TB;
				end
				4'd10: begin
					alu_a = ta_q; alu_b = tb_q; alu_sub = 1'b1; alu_use = 1'b1; dst = DST_TA;
				end
				4'd11: begin
					mx = ta_q; mk = {1'b0, dt_q};
				end
				4'd13: begin
					alu_a = hz_a; alu_b = mq_res; alu_sub = 1'b1;
					alu_use = 1'b1; mul_use = 1'b1;
				end
				default: begin
				end
			endcase
		end else begin
			case (step_q)
				4'd1: begin
					alu_a = hz_a; alu_b = hz_b; alu_sub = 1'b1; alu_use = e_inner; dst = DST_DA;
				end
				4'd2: begin
					alu_a = hz_a; alu_b = hz_b; alu_sub = 1'b1; alu_use = 1'b1; dst = DST_DB;
					mx = pex_a; mk = yp_q.b;
				end
				4'd3: begin
					mx = da_q; mk = yp_q.c;
				end
				4'd4: begin
					mx = da_q; mk = {1'b0, yp_q.ik};
					alu_a = mq_res; mul_use = 1'b1; dst = DST_T0;
				end
				4'd5: begin
					mx = pey_a; mk = xp_q.b;
					alu_a = t0_q; alu_b = mq_res; alu_use = 1'b1; mul_use = 1'b1; dst = DST_PA;
				end
				4'd6: begin
					mx = db_q; mk = xp_q.c;
					alu_a = mq_res; alu_b = pa_q; alu_use = 1'b1; mul_use = 1'b1; dst = DST_TA;
				end
				4'd7: begin
					mx = ta_q; mk = coeff_a;
					alu_a = mq_res; mul_use = 1'b1; dst = DST_T0;
				end
				4'd8: begin
					mx = db_q; mk = {1'b0, xp_q.ik};
					alu_a = t0_q; alu_b = mq_res; alu_use = 1'b1; mul_use = 1'b1; dst = DST_PB;
				end
				4'd9: begin
					alu_a = ex_a; alu_b = mq_res; alu_use = 1'b1; mul_use = 1'b1; dst = DST_TA;
				end
				4'd10: begin
					alu_a = mq_res; alu_b = pb_q; alu_use = 1'b1; mul_use = 1'b1; dst = DST_TB;
				end
				4'd11: begin
					mx = tb_q; mk = coeff_a;
				end
				4'd13: begin
					alu_a = ey_a; alu_b = mq_res; alu_sub = 1'b1;
					alu_use = 1'b1; mul_use = 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	assign alu_sum = alu_sub
		? ($signed({alu_a[VW-1], alu_a}) - $signed({alu_b[VW-1], alu_b}))
		: ($signed({alu_a[VW-1], alu_a}) + $signed({alu_b[VW-1], alu_b}));
	assign sres = sat_sum(alu_sum);

	fdtdc_qmul u_qmul (
		.clk (clk),
		.x   (mx),
		.k   (mk),
		.res (mq_res),
		.ovf (mq_ovf)
	);

	// Memory addressing, write enables and write data.
	always_comb begin
		we        = '0;
		rd        = '0;
		wr_addr   = {i_idx, j_idx};
		rd_addr_a = {i_idx, j_idx};
		rd_addr_b = {ci_q, cj_q};
		x_addr    = i_idx;
		y_addr    = j_idx;
		ex_wd     = '0;
		ey_wd     = '0;
		hz_wd     = '0;
		metal_wd  = 1'b0;
		phx_wd    = pa_q;
		phy_wd    = pb_q;
		pex_wd    = pa_q;
		pey_wd    = pb_q;
		unique case (state_q)
			ST_CLEAR: begin
				wr_addr = clr_q;
				we.ex = 1'b1; we.ey = 1'b1; we.hz = 1'b1; we.metal = 1'b1;
				we.phx = 1'b1; we.phy = 1'b1; we.pex = 1'b1; we.pey = 1'b1;
				phx_wd = '0; phy_wd = '0; pex_wd = '0; pey_wd = '0;
			end
			ST_IDLE: begin
				ex_wd    = e_x_value;
				ey_wd    = e_y_value;
				hz_wd    = h_z_value;
				metal_wd = is_metal;
				rd.rd_a  = accept && (kind == KIND_READ);
				if (accept && kind == KIND_WCELL && in_grid) begin
					we.ex = 1'b1; we.ey = 1'b1; we.hz = 1'b1;
					we.coeff = 1'b1; we.metal = 1'b1;
				end
				we.xprof = accept && (kind == KIND_WXPROF) && i_ok;
				we.yprof = accept && (kind == KIND_WYPROF) && j_ok;
			end
			ST_RUN: begin
				wr_addr    = {ci_q, cj_q};
				rd_addr_a  = {ci_q, cj_q};
				x_addr     = ci_q;
				y_addr     = cj_q;
				rd.rd_a    = (step_q == 4'd0);
				rd.rd_prof = (step_q == 4'd0);
				rd.rd_b    = (step_q == 4'd0) || (step_q == 4'd1);
				if (step_q == 4'd0) begin
					rd_addr_b = is_h ? {ci_q, cj_q + CW'(1)} : {ci_q, cj_q - CW'(1)};
				end else begin
					rd_addr_b = is_h ? {ci_q + RW'(1), cj_q} : {ci_q - RW'(1), cj_q};
				end
				hz_wd = sres.val;
				ex_wd = metal_a ? '0 : ta_q;
				ey_wd = metal_a ? '0 : sres.val;
				if (step_q == STEP_LAST) begin
					if (is_h) begin
						we.hz = 1'b1; we.phx = 1'b1; we.phy = 1'b1;
					end else begin
						we.ex = 1'b1; we.ey = 1'b1; we.pex = 1'b1; we.pey = 1'b1;
					end
				end else if (!is_h && step_q == 4'd1 && !e_inner && metal_a) begin
					// Border cell of the E sweep: only the conductor zeroing applies.
					we.ex = 1'b1; we.ey = 1'b1;
				end
			end
			ST_FINISH: begin
			end
			default: begin
			end
		endcase
	end

	assign prof_wd = '{b: decay_b, c: couple_c, ik: inv_kappa};

	fdtdc_store #(
		.GRID_ROWS (GRID_ROWS),
		.GRID_COLS (GRID_COLS)
	) u_store (
		.clk       (clk),
		.we        (we),
		.rd        (rd),
		.wr_addr   (wr_addr),
		.rd_addr_a (rd_addr_a),
		.rd_addr_b (rd_addr_b),
		.x_addr    (x_addr),
		.y_addr    (y_addr),
		.ex_wd     (ex_wd),
		.ey_wd     (ey_wd),
		.hz_wd     (hz_wd),
		.coeff_wd  (update_coeff),
		.metal_wd  (metal_wd),
		.phx_wd    (phx_wd),
		.phy_wd    (phy_wd),
		.pex_wd    (pex_wd),
		.pey_wd    (pey_wd),
		.prof_wd   (prof_wd),
		.ex_a      (ex_a),
		.ey_a      (ey_a),
		.hz_a      (hz_a),
		.coeff_a   (coeff_a),
		.metal_a   (metal_a),
		.phx_a     (phx_a),
		.phy_a     (phy_a),
		.pex_a     (pex_a),
		.pey_a     (pey_a),
		.ex_b      (ex_b),
		.ey_b      (ey_b),
		.hz_b      (hz_b),
		.xp_q      (xp_q),
		.yp_q      (yp_q)
	);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= EXT_W'(64);
			cols_q <= EXT_W'(64);
			dt_q   <= DT_W'(32768);
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_ROWS: rows_q <= cfg_data[EXT_W-1:0];
				CFG_COLS: cols_q <= cfg_data[EXT_W-1:0];
				CFG_DT:   dt_q   <= cfg_data[DT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Sequencer: clearing pass, item dispatch, cell walk and result hand-off.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_q     <= '0;
			kind_q    <= KIND_WCELL;
			in_grid_q <= 1'b0;
			flag_q    <= 1'b0;
			ci_q      <= '0;
			cj_q      <= '0;
			step_q    <= '0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == '1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						kind_q    <= kind;
						in_grid_q <= in_grid;
						ci_q      <= '0;
						cj_q      <= '0;
						step_q    <= '0;
						if (kind == KIND_HSWEEP || kind == KIND_ESWEEP) begin
							flag_q  <= 1'b0;
							state_q <= (nx == '0 || ny == '0) ? ST_FINISH : ST_RUN;
						end else begin
							state_q <= ST_FINISH;
						end
					end
				end
				ST_RUN: begin
					if ((alu_use && sres.ovf) || (mul_use && mq_ovf)) begin
						flag_q <= 1'b1;
					end
					if (cell_done) begin
						step_q <= '0;
						if (col_last) begin
							cj_q <= '0;
							if (row_last) begin
								state_q <= ST_FINISH;
							end else begin
								ci_q <= ci_q + RW'(1);
							end
						end else begin
							cj_q <= cj_q + CW'(1);
						end
					end else begin
						step_q <= step_q + 4'd1;
					end
				end
				ST_FINISH: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase
		end
	end

	// Cell datapath temporaries.
	always_ff @(posedge clk) begin
		if (state_q == ST_RUN) begin
			case (dst)
				DST_DA: da_q <= sres.val;
				DST_DB: db_q <= sres.val;
				DST_T0: t0_q <= sres.val;
				DST_PA: pa_q <= sres.val;
				DST_PB: pb_q <= sres.val;
				DST_TA: ta_q <= sres.val;
				DST_TB: tb_q <= sres.val;
				default: begin
				end
			endcase
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			if (kind_q == KIND_READ && in_grid_q) begin
				ex_out_q    <= ex_a;
				ey_out_q    <= ey_a;
				hz_out_q    <= hz_a;
				metal_out_q <= metal_a;
			end else begin
				ex_out_q    <= '0;
				ey_out_q    <= '0;
				hz_out_q    <= '0;
				metal_out_q <= 1'b0;
			end
			sat_out_q <= (kind_q == KIND_HSWEEP || kind_q == KIND_ESWEEP) ? flag_q : 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign e_x_out   = ex_out_q;
	assign e_y_out   = ey_out_q;
	assign h_z_out   = hz_out_q;
	assign metal_out = metal_out_q;
	assign saturated = sat_out_q;

	// The cell program never runs past its last step.
	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> (step_q <= STEP_LAST))
		else $error("cell step counter out of range");

	// No store is written while a result waits for hand-off.
	a_no_write_finish: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH) |-> (we == '0))
		else $error("store write while finishing");

	// An accepted sweep starts the cell walk or finishes at once.
	a_sweep_start: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (kind == KIND_HSWEEP || kind == KIND_ESWEEP))
		|=> (state_q == ST_RUN || state_q == ST_FINISH))
		else $error("sweep did not start");

	// A result only appears after the finishing state.
	a_out_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_FINISH))
		else $error("result loaded outside finish");

endmodule
